// ===== hw/rtl/hti_pkg.sv =====
`timescale 1ns / 1ps
package hti_pkg;
    localparam int SLOTS       = 512;
    localparam int MAX_MATCHES = 4;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int ENTRY_W     = 48;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_NOMATCH = 2'd2;

    typedef logic [SLOT_W-1:0]  t_addr;
    typedef logic [ENTRY_W-1:0] t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_DONE
    } t_state;
endpackage

// ===== hw/rtl/hti_if.sv =====
`timescale 1ns / 1ps
interface hti_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] phone;
    logic [15:0] offset;
    modport source (output valid, kind, phone, offset, input ready);
    modport sink   (input valid, kind, phone, offset, output ready);
endinterface

interface hti_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  match_count;
    logic [15:0] match_a;
    logic [15:0] match_b;
    logic [15:0] match_c;
    logic [15:0] match_d;
    modport source (output valid, status, match_count, match_a, match_b, match_c,
                    match_d, input ready);
    modport sink   (input valid, status, match_count, match_a, match_b, match_c,
                    match_d, output ready);
endinterface

// ===== hw/rtl/phone_hash_index_table.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Modport  Payload
// i_req     in   sink     kind[1:0], phone[63:0], offset[15:0]
// o_rsp     out  source   status[1:0], match_count[2:0], match_a..match_d[15:0]
//
// Per transaction: accept, hash and home slot, a scan of up to SLOTS slots, result.
// The scan is bound by the
// single read port of the slot memory, one slot per cycle.
// Reset: a clearing pass writes every slot to zero, i_req.ready low.
// One transaction is in work at a time; a held result in o_rsp does not block the
// next accept, only the completion of that next transaction.
module phone_hash_index_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hti_req_if.sink    i_req,
    hti_rsp_if.source  o_rsp
);
    import hti_pkg::*;

    t_state        r_state, n_state;
    logic [1:0]    r_kind, n_kind;
    logic [15:0]   r_off, n_off;
    logic [31:0]   r_hash, n_hash;
    t_addr         r_addr, n_addr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic          r_rd_vld, n_rd_vld;
    t_addr         r_q_addr, n_q_addr;
    logic [2:0]    r_mcnt, n_mcnt;
    logic [15:0]   r_match [4];
    logic [15:0]   n_match [4];
    logic [1:0]    r_status, n_status;

    // output register
    logic          r_ovld, n_ovld;
    logic [1:0]    r_ostat, n_ostat;
    logic [2:0]    r_ocnt, n_ocnt;
    logic [15:0]   r_om [4];
    logic [15:0]   n_om [4];

    logic          w_hstart, w_hdone;
    logic [31:0]   w_hash;
    t_addr         w_home;
    logic          w_we;
    t_addr         w_waddr, w_raddr;
    t_entry        w_wdata, w_rdata;
    logic [15:0]   w_qoff;
    logic [31:0]   w_qhash;

    hti_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_phone (i_req.phone),
        .o_done  (w_hdone),
        .o_hash  (w_hash),
        .o_home  (w_home)
    );

    hti_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_qoff  = w_rdata[15:0];
    assign w_qhash = w_rdata[47:16];

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_off    = r_off;
        n_hash   = r_hash;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_rd_vld = r_rd_vld;
        n_q_addr = r_q_addr;
        n_mcnt   = r_mcnt;
        n_match  = r_match;
        n_status = r_status;
        n_ovld   = r_ovld;
        n_ostat  = r_ostat;
        n_ocnt   = r_ocnt;
        n_om     = r_om;
        w_hstart = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_q_addr;
        w_wdata  = '0;
        w_raddr  = r_addr;
        i_req.ready = 1'b0;

        if (r_ovld && o_rsp.ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                if (r_addr == SLOT_W'(SLOTS - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + SLOT_W'(1);
                end
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    w_hstart = 1'b1;
                    n_kind   = i_req.kind;
                    n_off    = i_req.offset;
                    n_state  = ST_HASH;
                end
            end
            ST_HASH: begin
                if (w_hdone) begin
                    n_hash   = w_hash;
                    n_mcnt   = '0;
                    n_match  = '{default: 16'd0};
                    n_cnt    = '0;
                    n_rd_vld = 1'b0;
                    n_addr   = (r_kind == KIND_REMOVE) ? '0 : w_home;
                    case (r_kind)
                        KIND_INSERT: n_status = STAT_FULL;
                        KIND_REMOVE: n_status = STAT_NOMATCH;
                        default:     n_status = STAT_DONE;
                    endcase
                    if (r_kind == KIND_LOOKUP) begin
                        n_state = ST_SCAN;
                    end else if ((r_kind == KIND_INSERT || r_kind == KIND_REMOVE)
                                 && r_off != 16'd0) begin
                        n_state = ST_SCAN;
                    end else begin
                        // zero offset insert is a no-op that succeeds; unused kind is all zero
                        if (r_kind == KIND_INSERT) begin
                            n_status = STAT_DONE;
                        end
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, examine the previous read's data
                if (r_cnt < CNT_W'(SLOTS)) begin
                    w_raddr  = r_addr;
                    n_rd_vld = 1'b1;
                    n_q_addr = r_addr;
                    n_cnt    = r_cnt + CNT_W'(1);
                    n_addr   = (r_addr == SLOT_W'(SLOTS - 1)) ? '0 : r_addr + SLOT_W'(1);
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_state = ST_DONE;
                    end
                end
                if (r_rd_vld) begin
                    case (r_kind)
                        KIND_INSERT: begin
                            if (w_qoff == 16'd0) begin
                                w_we     = 1'b1;
                                w_wdata  = {r_hash, r_off};
                                n_status = STAT_DONE;
                                n_state  = ST_DONE;
                            end
                        end
                        KIND_REMOVE: begin
                            if (w_qoff == r_off && w_qhash == r_hash) begin
                                w_we     = 1'b1;
                                n_status = STAT_DONE;
                                n_state  = ST_DONE;
                            end
                        end
                        default: begin
                            if (w_qoff != 16'd0 && w_qhash == r_hash) begin
                                n_match[r_mcnt[1:0]] = w_qoff;
                                n_mcnt = r_mcnt + 3'd1;
                                if (r_mcnt + 3'd1 == 3'(MAX_MATCHES)) begin
                                    n_state = ST_DONE;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld  = 1'b1;
                    n_ostat = r_status;
                    n_ocnt  = r_mcnt;
                    n_om    = r_match;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_mcnt   <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
            r_mcnt   <= n_mcnt;
            r_ovld   <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_off    <= n_off;
        r_hash   <= n_hash;
        r_q_addr <= n_q_addr;
        r_match  <= n_match;
        r_status <= n_status;
        r_ostat  <= n_ostat;
        r_ocnt   <= n_ocnt;
        r_om     <= n_om;
    end

    assign o_rsp.valid       = r_ovld;
    assign o_rsp.status      = r_ostat;
    assign o_rsp.match_count = r_ocnt;
    assign o_rsp.match_a     = r_om[0];
    assign o_rsp.match_b     = r_om[1];
    assign o_rsp.match_c     = r_om[2];
    assign o_rsp.match_d     = r_om[3];
endmodule

// ===== hw/rtl/hti_hash.sv =====
`timescale 1ns / 1ps
module hti_hash (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_phone,
    output logic                 o_done,
    output logic [31:0]          o_hash,
    output hti_pkg::t_addr       o_home
);
    import hti_pkg::*;

    // steps 0..7: FNV rounds, one byte per step, low byte first
    localparam logic [2:0] LAST_STEP = 3'd7;

    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_step;
    logic [31:0]   r_h;
    logic [63:0]   r_key;

    logic [31:0]   w_prod;

    assign w_prod = (r_h ^ {24'd0, r_key[7:0]}) * FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h   <= FNV_BASIS;
            r_key <= i_phone;
        end else if (r_busy) begin
            r_h   <= w_prod;
            r_key <= {8'd0, r_key[63:8]};
        end
    end

    assign o_done = r_done;
    assign o_hash = r_h;
    // SLOTS is a power of two: home slot is the low hash bits
    assign o_home = r_h[SLOT_W-1:0];
endmodule

// ===== hw/rtl/hti_ram.sv =====
`timescale 1ns / 1ps
module hti_ram (
    input  logic              i_clk,
    input  logic              i_we,
    input  hti_pkg::t_addr    i_waddr,
    input  hti_pkg::t_entry   i_wdata,
    input  hti_pkg::t_addr    i_raddr,
    output hti_pkg::t_entry   o_rdata
);
    import hti_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule
